// ----- rtl/gmd_pkg.sv -----
// shared types and constants for the gradient magnitude and direction block
`default_nettype none
package gmd_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int WID_W      = 12;
  localparam int HGT_W      = 13;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIZE   = 3;

  // magnitude root width and the squared-sum width it comes from
  localparam int MAG_W = 17;
  localparam int SUM_W = 2 * MAG_W;
  localparam int REM_W = MAG_W + 3;

  // tan(pi/8) and tan(3pi/8) in q16
  localparam logic [SUM_W-1:0] TAN_LO_Q16 = 34'd27146;
  localparam logic [SUM_W-1:0] TAN_HI_Q16 = 34'd158218;

  typedef enum logic [1:0] {
    ANG_0   = 2'd0,
    ANG_45  = 2'd1,
    ANG_90  = 2'd2,
    ANG_135 = 2'd3
  } ang_class_t;

endpackage
`default_nettype wire

// ----- rtl/gradient_magnitude_direction.sv -----
// gradient magnitude and quantized direction over a raster pixel stream
// Usage:
//   in_pixel arrives in raster order on a valid/ready channel; one result per
//   pixel of row 2 and later leaves on the out_ channel, describing the pixel
//   directly above it (rows 1 .. height-2 of the frame give results).
//   out_end_of_row marks the last result of a row, out_end_of_frame the last
//   result of the frame.
//   cfg_we/cfg_index/cfg_wdata write image_width (0) and image_height (1);
//   write them only while the block holds no transaction.
// Throughput: one pixel per clock, sustained while the receiver keeps out_ready high.
// Pipeline: each accepted pixel passes through the line ram read, gradient,
//   squares and tangent products, sum and class,
//   then 17 stages of the bit-per-stage square root.
// Reset: clears the counters, the pipeline valid bits and the registers
//   (width 2048, height 2048); line ram contents are kept as they are.
// Stall: each stage advances when it is empty or the stage after it moves,
//   so a stalled receiver fills the bubbles and then drops in_ready.
`default_nettype none
module gradient_magnitude_direction #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [15:0]                   in_pixel,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [gmd_pkg::MAG_W-1:0]     out_magnitude,
  output      logic [1:0]                    out_angle_class,
  output      logic                          out_end_of_row,
  output      logic                          out_end_of_frame,
  input  wire logic                          cfg_we,
  input  wire logic [gmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gmd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PB    = PIXEL_BITS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CMP_W = (CW + 1 > gmd_pkg::WID_W) ? CW + 1 : gmd_pkg::WID_W;
  localparam int SUM_W = gmd_pkg::SUM_W;
  localparam int MAG_W = gmd_pkg::MAG_W;
  localparam int REM_W = gmd_pkg::REM_W;
  localparam int HGT_W = gmd_pkg::HGT_W;
  localparam int ROW_W = gmd_pkg::ROW_W;
  localparam int NSQ   = MAG_W;
  localparam int SQ0   = 5;
  localparam int NS    = SQ0 + NSQ - 1;

  // ---------------------------------------------------------------- config
  logic [gmd_pkg::WID_W-1:0] image_width_r;
  logic [HGT_W-1:0]          image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= gmd_pkg::WID_W'(2048);
      image_height_r <= HGT_W'(2048);
    end else if (cfg_we) begin
      case (cfg_index)
        gmd_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[gmd_pkg::WID_W-1:0];
        gmd_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CMP_W-1:0] w_reg, w_eff, w_last;
  logic [HGT_W-1:0] h_eff, h_last;

  always_comb begin
    w_reg = CMP_W'(image_width_r);
    if (w_reg < CMP_W'(gmd_pkg::MIN_SIZE)) begin
      w_eff = CMP_W'(gmd_pkg::MIN_SIZE);
    end else if (w_reg > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_reg;
    end
    w_last = w_eff - CMP_W'(1);
    if (image_height_r < HGT_W'(gmd_pkg::MIN_SIZE)) begin
      h_eff = HGT_W'(gmd_pkg::MIN_SIZE);
    end else if (image_height_r > HGT_W'(gmd_pkg::MAX_HEIGHT)) begin
      h_eff = HGT_W'(gmd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    h_last = h_eff - HGT_W'(1);
  end

  // ---------------------------------------------------------- stage control
  logic [NS:1]   v_r;
  logic [NS+1:1] en;
  logic [NS:1]   v_in;
  logic          s1_emit_r;

  always_comb begin
    en[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_in[1] = in_valid;
    // rows above row 2 only update the line buffers
    v_in[2] = v_r[1] && s1_emit_r;
    for (int k = 3; k <= NS; k++) begin
      v_in[k] = v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  logic accept;
  assign in_ready = en[1];
  assign accept   = in_valid && en[1];

  // ------------------------------------------------------- counters, stage 0
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;
  logic [PB-1:0]    pix;
  logic             row_end, frame_end, emit, use_mid;
  logic [CW-1:0]    raddr_right;

  assign pix       = in_pixel[PB-1:0];
  assign row_end   = CMP_W'(col_r) >= w_last;
  assign frame_end = row_end && (HGT_W'(row_r) >= h_last);
  assign emit      = row_r >= ROW_W'(2);
  assign use_mid   = row_end || (col_r == CW'(MAX_WIDTH - 1));
  assign raddr_right = use_mid ? col_r : col_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // ------------------------------------------------------------ line buffers
  logic [PB-1:0] mid, right_raw, up;
  logic [CW-1:0] s1_x_r;
  logic          up_we;

  gmd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(col_r),
    .wdata(pix),
    .re   (en[1]),
    .raddr(col_r),
    .rdata(mid)
  );

  // copy of the middle line so the right neighbor reads in the same cycle
  gmd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_right_ram (
    .clk  (clk),
    .we   (accept),
    .waddr(col_r),
    .wdata(pix),
    .re   (en[1]),
    .raddr(raddr_right),
    .rdata(right_raw)
  );

  // middle row moves up once it has been read for this column
  assign up_we = v_r[1] && en[2];

  gmd_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_up_ram (
    .clk  (clk),
    .we   (up_we),
    .waddr(s1_x_r),
    .wdata(mid),
    .re   (en[1]),
    .raddr(col_r),
    .rdata(up)
  );

  // ----------------------------------------------------------------- stage 1
  logic [PB-1:0] s1_pix_r, prev_mid_r;
  logic          s1_first_r, s1_midr_r, s1_eor_r, s1_eof_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pix_r   <= pix;
      s1_x_r     <= col_r;
      s1_first_r <= (col_r == '0);
      s1_midr_r  <= use_mid;
      s1_emit_r  <= emit;
      s1_eor_r   <= row_end;
      s1_eof_r   <= frame_end;
    end
    if (up_we) begin
      prev_mid_r <= mid;
    end
  end

  logic [PB-1:0] left_px, right_px;
  assign left_px  = s1_first_r ? mid : prev_mid_r;
  assign right_px = s1_midr_r ? mid : right_raw;

  // ----------------------------------------------------------------- stage 2
  logic signed [PB:0] s2_gx_r, s2_gy_r;
  logic               s2_eor_r, s2_eof_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_gx_r  <= {1'b0, right_px} - {1'b0, left_px};
      s2_gy_r  <= {1'b0, up} - {1'b0, s1_pix_r};
      s2_eor_r <= s1_eor_r;
      s2_eof_r <= s1_eof_r;
    end
  end

  logic [PB-1:0]    ax, ay;
  logic [2*PB-1:0]  ax_w, ay_w;
  logic [SUM_W-1:0] bx_w;

  assign ax   = s2_gx_r[PB] ? PB'(-s2_gx_r) : s2_gx_r[PB-1:0];
  assign ay   = s2_gy_r[PB] ? PB'(-s2_gy_r) : s2_gy_r[PB-1:0];
  assign ax_w = (2*PB)'(ax);
  assign ay_w = (2*PB)'(ay);
  assign bx_w = SUM_W'(ax);

  // ----------------------------------------------------------------- stage 3
  logic [2*PB-1:0]  s3_sqx_r, s3_sqy_r;
  logic [SUM_W-1:0] s3_lhs_r, s3_t1_r, s3_t2_r;
  logic             s3_gxz_r, s3_gyz_r, s3_pos_r, s3_eor_r, s3_eof_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_sqx_r <= ax_w * ax_w;
      s3_sqy_r <= ay_w * ay_w;
      s3_lhs_r <= SUM_W'(ay) << 16;
      s3_t1_r  <= gmd_pkg::TAN_LO_Q16 * bx_w;
      s3_t2_r  <= gmd_pkg::TAN_HI_Q16 * bx_w;
      s3_gxz_r <= (s2_gx_r == '0);
      s3_gyz_r <= (s2_gy_r == '0);
      s3_pos_r <= (s2_gx_r[PB] == s2_gy_r[PB]);
      s3_eor_r <= s2_eor_r;
      s3_eof_r <= s2_eof_r;
    end
  end

  gmd_pkg::ang_class_t ang;

  always_comb begin
    if (s3_gxz_r) begin
      ang = gmd_pkg::ANG_90;
    end else if (s3_gyz_r) begin
      ang = gmd_pkg::ANG_0;
    end else if (s3_pos_r) begin
      if (s3_lhs_r < s3_t1_r) begin
        ang = gmd_pkg::ANG_0;
      end else if (s3_lhs_r < s3_t2_r) begin
        ang = gmd_pkg::ANG_45;
      end else begin
        ang = gmd_pkg::ANG_90;
      end
    end else begin
      // negative slope: ties fall to the lower class
      if (s3_lhs_r <= s3_t1_r) begin
        ang = gmd_pkg::ANG_0;
      end else if (s3_lhs_r <= s3_t2_r) begin
        ang = gmd_pkg::ANG_135;
      end else begin
        ang = gmd_pkg::ANG_90;
      end
    end
  end

  // ----------------------------------------------------------------- stage 4
  logic [SUM_W-1:0]    s4_sum_r;
  gmd_pkg::ang_class_t s4_ang_r;
  logic                s4_eor_r, s4_eof_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_sum_r <= SUM_W'(s3_sqx_r) + SUM_W'(s3_sqy_r);
      s4_ang_r <= ang;
      s4_eor_r <= s3_eor_r;
      s4_eof_r <= s3_eof_r;
    end
  end

  // ------------------------------------------------- square root, 1 bit/stage
  logic [REM_W-1:0]    sq_rem_r  [NSQ];
  logic [MAG_W-1:0]    sq_root_r [NSQ];
  logic [SUM_W-1:0]    sq_rest_r [NSQ-1];
  gmd_pkg::ang_class_t sq_ang_r  [NSQ];
  logic                sq_eor_r  [NSQ];
  logic                sq_eof_r  [NSQ];

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic [REM_W-1:0]    rem_in, cur, trial;
    logic [MAG_W-1:0]    root_in;
    logic [SUM_W-1:0]    rest_in;
    gmd_pkg::ang_class_t ang_in;
    logic                eor_in, eof_in, take;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rest_in = s4_sum_r;
      assign ang_in  = s4_ang_r;
      assign eor_in  = s4_eor_r;
      assign eof_in  = s4_eof_r;
    end else begin : g_next
      assign rem_in  = sq_rem_r[j-1];
      assign root_in = sq_root_r[j-1];
      assign rest_in = sq_rest_r[j-1];
      assign ang_in  = sq_ang_r[j-1];
      assign eor_in  = sq_eor_r[j-1];
      assign eof_in  = sq_eof_r[j-1];
    end

    assign cur   = {rem_in[REM_W-3:0], rest_in[SUM_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (en[SQ0+j]) begin
        sq_rem_r[j]  <= take ? cur - trial : cur;
        sq_root_r[j] <= {root_in[MAG_W-2:0], take};
        sq_ang_r[j]  <= ang_in;
        sq_eor_r[j]  <= eor_in;
        sq_eof_r[j]  <= eof_in;
      end
    end

    if (j < NSQ - 1) begin : g_rest
      always_ff @(posedge clk) begin
        if (en[SQ0+j]) begin
          sq_rest_r[j] <= rest_in << 2;
        end
      end
    end
  end

  // ------------------------------------------------------------------ output
  assign out_valid        = v_r[NS];
  assign out_magnitude    = sq_root_r[NSQ-1];
  assign out_angle_class  = sq_ang_r[NSQ-1];
  assign out_end_of_row   = sq_eor_r[NSQ-1];
  assign out_end_of_frame = sq_eof_r[NSQ-1];

endmodule
`default_nettype wire

// ----- rtl/gmd_ram.sv -----
// simple dual-port line ram with registered read
`default_nettype none
module gmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same address is written
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gmd_checker.sv -----
// port-level assertions for the gradient magnitude and direction block
`default_nettype none
module gmd_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [gmd_pkg::MAG_W-1:0] out_magnitude,
  input wire logic [1:0]                out_angle_class,
  input wire logic                      out_end_of_row,
  input wire logic                      out_end_of_frame
);

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_magnitude)
      && $stable(out_angle_class) && $stable(out_end_of_row)
      && $stable(out_end_of_frame))
    else $error("stalled result changed");

  // the last result of a frame also closes its row
  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_end_of_row)
    else $error("end of frame without end of row");

  // zero magnitude means no gradient, which is classed as vertical
  a_flat_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_magnitude == '0) |-> (out_angle_class == gmd_pkg::ANG_90))
    else $error("zero gradient not classed as 90 degrees");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind gradient_magnitude_direction gmd_checker u_gmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_magnitude   (out_magnitude),
  .out_angle_class (out_angle_class),
  .out_end_of_row  (out_end_of_row),
  .out_end_of_frame(out_end_of_frame)
);
`default_nettype wire

// ----- bench/tb_gradient_magnitude_direction.sv -----
// testbench for the gradient magnitude and direction block
`default_nettype none
module tb_gradient_magnitude_direction;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH    = 2048;
  localparam int TALLEST       = 4096;
  localparam int SMALLEST      = 3;
  localparam longint TAN_LO    = 27146;
  localparam longint TAN_HI    = 158218;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PIXELS = 150;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef struct {
    logic [gmd_pkg::MAG_W-1:0] magnitude;
    gmd_pkg::ang_class_t       angle;
    logic                      end_of_row;
    logic                      end_of_frame;
  } gradient_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [15:0]                    in_pixel = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [gmd_pkg::MAG_W-1:0]      out_magnitude;
  logic [1:0]                     out_angle_class;
  logic                           out_end_of_row;
  logic                           out_end_of_frame;
  logic                           cfg_we = 1'b0;
  logic [gmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gmd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the block: registers, line stores and raster position
  logic [gmd_pkg::WID_W-1:0] width_reg = 12'd2048;
  logic [gmd_pkg::HGT_W-1:0] height_reg = 13'd2048;
  bit [15:0]                 upper_row [LINE_DEPTH];
  bit [15:0]                 middle_row [LINE_DEPTH];
  int                        col_idx = 0;
  int                        row_idx = 0;
  int                        prev_mid = 0;

  logic [15:0] pixel_q [$];
  gradient_t   expected_gradients [$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          hold_requests = 0;
  int          holds_started = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;

  gradient_magnitude_direction dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_magnitude   (out_magnitude),
    .out_angle_class (out_angle_class),
    .out_end_of_row  (out_end_of_row),
    .out_end_of_frame(out_end_of_frame),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int active_width();
    int w;
    w = int'(width_reg);
    if (w < SMALLEST) w = SMALLEST;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int active_height();
    int h;
    h = int'(height_reg);
    if (h < SMALLEST) h = SMALLEST;
    if (h > TALLEST) h = TALLEST;
    return h;
  endfunction

  function automatic logic [gmd_pkg::MAG_W-1:0] floor_sqrt(input longint unsigned v);
    logic [gmd_pkg::MAG_W-1:0] root;
    longint unsigned           trial;
    root = '0;
    for (int b = gmd_pkg::MAG_W - 1; b >= 0; b--) begin
      trial = 64'(root) | (64'(1) << b);
      if (trial * trial <= v) root = trial[gmd_pkg::MAG_W-1:0];
    end
    return root;
  endfunction

  function automatic gmd_pkg::ang_class_t quantize_direction(input int gx, input int gy);
    longint rise, run, lhs, lo_bound, hi_bound;
    bit     same_sign;
    if (gx == 0) return gmd_pkg::ANG_90;
    if (gy == 0) return gmd_pkg::ANG_0;
    rise = (gy < 0) ? -longint'(gy) : longint'(gy);
    run = (gx < 0) ? -longint'(gx) : longint'(gx);
    same_sign = (gx > 0) == (gy > 0);
    lhs = rise << 16;
    lo_bound = TAN_LO * run;
    hi_bound = TAN_HI * run;
    // ties go to the lower class only when the tangent is negative
    if (same_sign) begin
      if (lhs < lo_bound) return gmd_pkg::ANG_0;
      if (lhs < hi_bound) return gmd_pkg::ANG_45;
      return gmd_pkg::ANG_90;
    end
    if (lhs <= lo_bound) return gmd_pkg::ANG_0;
    if (lhs <= hi_bound) return gmd_pkg::ANG_135;
    return gmd_pkg::ANG_90;
  endfunction

  task automatic absorb_pixel(input logic [15:0] pix);
    int        w, h, x, y, mid, left, right, up, gx, gy;
    bit        row_end, frame_end;
    gradient_t g;
    w = active_width();
    h = active_height();
    x = col_idx % LINE_DEPTH;
    y = row_idx;
    row_end = col_idx >= w - 1;
    frame_end = row_end && (y >= h - 1);
    mid = int'(middle_row[x]);
    left = (x == 0) ? mid : prev_mid;
    right = (!row_end && x + 1 < LINE_DEPTH) ? int'(middle_row[x + 1]) : mid;
    up = int'(upper_row[x]);
    if (y >= 2) begin
      gx = right - left;
      gy = up - int'(pix);
      g.magnitude = floor_sqrt(longint'(gx) * longint'(gx) + longint'(gy) * longint'(gy));
      g.angle = quantize_direction(gx, gy);
      g.end_of_row = row_end;
      g.end_of_frame = frame_end;
      expected_gradients.push_back(g);
    end
    prev_mid = mid;
    upper_row[x] = mid[15:0];
    middle_row[x] = pix;
    if (row_end) begin
      col_idx = 0;
      prev_mid = 0;
      row_idx = frame_end ? 0 : y + 1;
    end else begin
      col_idx++;
    end
  endtask

  function automatic int pixels_to_frame_end();
    int w, h, n;
    w = active_width();
    h = active_height();
    n = (col_idx >= w - 1) ? 1 : w - col_idx;
    if (row_idx < h - 1) n += (h - 1 - row_idx) * w;
    return n;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // input side: holds each transaction until it is taken, random gaps between
  always @(posedge clk) begin : pixel_driver
    int roll;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) absorb_pixel(in_pixel);
      if (in_valid && !in_ready) begin
        // stalled: keep offering the same pixel
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        in_pixel <= pixel_q.pop_front();
        if ($urandom_range(0, 63) == 0) sender_calm = !sender_calm;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 60) gap_left = 0;
        else if (roll < 95) gap_left = $urandom_range(1, 3);
        else gap_left = $urandom_range(8, 30);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: check each transaction, throttle ready
  always @(posedge clk) begin : result_monitor
    gradient_t want;
    int        roll;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_gradients.size() == 0) begin
          report_mismatch("result with nothing pending, magnitude",
                          longint'(out_magnitude), -1);
        end else begin
          want = expected_gradients.pop_front();
          if (out_magnitude !== want.magnitude)
            report_mismatch("magnitude", longint'(out_magnitude),
                            longint'(want.magnitude));
          if (out_angle_class !== want.angle)
            report_mismatch("angle_class", longint'(out_angle_class),
                            longint'(want.angle));
          if (out_end_of_row !== want.end_of_row)
            report_mismatch("end_of_row", longint'(out_end_of_row),
                            longint'(want.end_of_row));
          if (out_end_of_frame !== want.end_of_frame)
            report_mismatch("end_of_frame", longint'(out_end_of_frame),
                            longint'(want.end_of_frame));
        end
      end
      // a requested long hold starts once results are flowing
      if (holds_started != hold_requests && out_valid) begin
        holds_started++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) receiver_calm = !receiver_calm;
        roll = $urandom_range(0, 99);
        if (receiver_calm || roll < 65) begin
          out_ready <= 1'b1;
        end else if (roll < 97) begin
          out_ready <= 1'b0;
          stall_left = $urandom_range(0, 3);
        end else begin
          out_ready <= 1'b0;
          stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || expected_gradients.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [gmd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [gmd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == gmd_pkg::REG_IMAGE_WIDTH) width_reg = data[gmd_pkg::WID_W-1:0];
    else height_reg = data[gmd_pkg::HGT_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [gmd_pkg::CFG_DATA_W-1:0] width_data,
                              input logic [gmd_pkg::CFG_DATA_W-1:0] height_data);
    write_register(gmd_pkg::REG_IMAGE_WIDTH, width_data);
    write_register(gmd_pkg::REG_IMAGE_HEIGHT, height_data);
  endtask

  task automatic push_pixels(input int count);
    int          roll;
    logic [15:0] value;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 7);
      case (roll)
        0, 1, 2: value = 16'($urandom_range(0, 65535));
        3:       value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        4, 5:    value = 16'($urandom_range(100, 103));  // near-flat patches
        6:       value = 16'($urandom_range(0, 255));
        default: value = 16'hFFFF - 16'($urandom_range(0, 255));
      endcase
      pixel_q.push_back(value);
    end
  endtask

  initial begin : stimulus
    logic [15:0]                    directed_frame [18];
    logic [gmd_pkg::WID_W-1:0]      w_raw;
    logic [gmd_pkg::CFG_DATA_W-1:0] w_data;
    logic [gmd_pkg::HGT_W-1:0]      h_raw;
    int                             random_pixels;
    int                             style, rows, cut, n;
    // 3 wide, 6 tall: zero gradient, flat, vertical, both maxima and the
    // exact tan(pi/8) tie with either sign of the tangent
    directed_frame = '{16'd0,     16'd65535, 16'd13573,
                       16'd0,     16'd0,     16'd32768,
                       16'd65535, 16'd65535, 16'd0,
                       16'd0,     16'd65535, 16'd13573,
                       16'd0,     16'd65535, 16'd32767,
                       16'd65535, 16'd0,     16'd0};
    random_pixels = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_geometry(13'd0, 13'd6);
    foreach (directed_frame[i]) pixel_q.push_back(directed_frame[i]);
    wait_until_idle();

    // wide rows and one long receiver hold
    set_geometry(13'd64, 13'd2);
    hold_requests++;
    push_pixels(pixels_to_frame_end());
    wait_until_idle();

    // exact maxima, then the width shrinks in row 0 and the height later
    set_geometry(13'd2048, 13'd4096);
    push_pixels(7);
    wait_until_idle();
    write_register(gmd_pkg::REG_IMAGE_WIDTH, 13'd0);
    push_pixels(7);
    wait_until_idle();
    write_register(gmd_pkg::REG_IMAGE_HEIGHT, 13'd0);
    push_pixels(pixels_to_frame_end());
    wait_until_idle();

    // saturated height, frame cut short by a height write
    set_geometry(13'd3, 13'd8191);
    push_pixels(12);
    wait_until_idle();
    write_register(gmd_pkg::REG_IMAGE_HEIGHT, 13'd4);
    push_pixels(pixels_to_frame_end());
    wait_until_idle();

    while (random_pixels < RANDOM_PIXELS) begin
      w_raw = gmd_pkg::WID_W'(($urandom_range(0, 5) == 0) ? $urandom_range(13, 40)
                                                          : $urandom_range(0, 12));
      w_data = gmd_pkg::CFG_DATA_W'(w_raw);
      w_data[gmd_pkg::CFG_DATA_W-1] = 1'($urandom_range(0, 1));
      h_raw = gmd_pkg::HGT_W'($urandom_range(0, 7));
      style = $urandom_range(0, 7);
      if (style == 0) begin
        // tall frame ended early by lowering the height mid-frame
        set_geometry(w_data, gmd_pkg::CFG_DATA_W'($urandom_range(16, 8191)));
        rows = $urandom_range(2, 5);
        n = rows * active_width();
        push_pixels(n);
        random_pixels += n;
        wait_until_idle();
        write_register(gmd_pkg::REG_IMAGE_HEIGHT,
                       gmd_pkg::CFG_DATA_W'($urandom_range(0, rows + 1)));
      end else if (style == 1) begin
        // width only ever shrinks inside a frame
        set_geometry(w_data, h_raw);
        cut = $urandom_range(1, pixels_to_frame_end() - 1);
        push_pixels(cut);
        random_pixels += cut;
        wait_until_idle();
        write_register(gmd_pkg::REG_IMAGE_WIDTH,
                       gmd_pkg::CFG_DATA_W'($urandom_range(0, active_width() - 1)));
      end else begin
        set_geometry(w_data, h_raw);
        if (style == 2) begin
          // sender pauses until everything pending has come out
          cut = pixels_to_frame_end() / 2;
          push_pixels(cut);
          random_pixels += cut;
          wait_until_idle();
        end
        if (style == 3) hold_requests++;
      end
      n = pixels_to_frame_end();
      push_pixels(n);
      random_pixels += n;
      wait_until_idle();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
